// ----- src/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, command codes, character codes and transaction payloads of
// the terminal character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CMD_W  = 2;
  localparam int CODE_W = 8;
  localparam int COL_W  = 6;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 7;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CODE_W-1:0] CODE_MASK = 8'h7F;
  localparam logic [CELL_W-1:0] FOLD_FROM = 7'h60;
  localparam logic [CELL_W-1:0] FOLD_MASK = 7'h5F;
  localparam logic [CELL_W-1:0] CODE_CR   = 7'h0D;
  localparam logic [CELL_W-1:0] PRINT_LO  = 7'h20;
  localparam logic [CELL_W-1:0] PRINT_HI  = 7'h5F;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CODE_W-1:0] char_code;
    logic [COL_W-1:0]  read_col;
    logic [ROW_W-1:0]  read_row;
  } req_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_char;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
  } rsp_t;

endpackage

// ----- src/tcw_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface tcw_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/terminal_char_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_char_writer
// Text store of a glass terminal with write cursor, scrolling and cell reads.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A write, clear or ignored command
// passes through accept, execute and respond states; a read adds a
// read-data state before respond, as the cell RAM has registered read
// data. The first printable character written into a blank row first
// sweeps that row to zero through the single RAM port and then runs the
// execute state again. Blank rows are tracked by one valid bit per
// physical row, so reset and the clear command take effect at once and
// no clearing pass over the RAM is needed; a scroll only drops the valid
// bit of the row that leaves the top.
module terminal_char_writer #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcw_stream_if.sink   in_i,
  tcw_stream_if.source out_o
);

  localparam int CIW   = $clog2(COLUMNS);
  localparam int RIW   = $clog2(ROWS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [CIW:0]    COL_END  = (CIW+1)'(COLUMNS);
  localparam logic [CIW:0]    COL_ONE  = (CIW+1)'(1);
  localparam logic [CIW-1:0]  COL_LAST = CIW'(COLUMNS - 1);
  localparam logic [RIW:0]    ROW_END  = (RIW+1)'(ROWS);
  localparam logic [RIW-1:0]  ROW_LAST = RIW'(ROWS - 1);
  localparam logic [AW-1:0]   ROW_SPAN = AW'(COLUMNS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_RDATA,
    ST_RESP
  } state_e;

  function automatic logic [RIW-1:0] phys_row(input logic [RIW-1:0] r,
                                              input logic [RIW-1:0] t);
    logic [RIW:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= ROW_END) begin
      s = s - ROW_END;
    end
    return s[RIW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RIW-1:0] prow,
                                              input logic [CIW-1:0] col);
    return AW'(prow) * ROW_SPAN + AW'(col);
  endfunction

  state_e                       state_q, state_d;
  logic [tcw_pkg::CMD_W-1:0]    cmd_q, cmd_d;
  logic [tcw_pkg::CELL_W-1:0]   code_q, code_d;
  logic [tcw_pkg::COL_W-1:0]    rcol_q, rcol_d;
  logic [tcw_pkg::ROW_W-1:0]    rrow_q, rrow_d;
  logic [CIW-1:0]               cursor_col_q, cursor_col_d;
  logic [RIW-1:0]               cursor_row_q, cursor_row_d;
  logic [RIW-1:0]               top_q, top_d;
  logic [CIW-1:0]               fill_q, fill_d;
  logic                         row_valid_q [ROWS];
  logic                         row_valid_d [ROWS];
  logic [tcw_pkg::CELL_W-1:0]   cell_q, cell_d;
  logic                         scrolled_q, scrolled_d;

  logic [tcw_pkg::CELL_W-1:0]   code_in;
  logic                         printable;
  logic                         is_cr;
  logic [CIW:0]                 col_adv;
  logic                         wrap;
  logic [RIW:0]                 row_adv;
  logic [RIW-1:0]               cur_prow;
  logic [RIW-1:0]               rd_prow;
  logic                         rd_in_range;
  logic [RIW-1:0]               top_next;

  logic                         ram_we;
  logic [AW-1:0]                ram_addr;
  logic [tcw_pkg::CELL_W-1:0]   ram_wdata;
  logic [tcw_pkg::CELL_W-1:0]   ram_rdata;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Mask to seven bits and fold lower case onto upper case
  always_comb begin
    code_in = 7'(in_i.data.char_code & tcw_pkg::CODE_MASK);
    if (code_in >= tcw_pkg::FOLD_FROM) begin
      code_in = code_in & tcw_pkg::FOLD_MASK;
    end
  end

  assign printable   = (code_q >= tcw_pkg::PRINT_LO) && (code_q <= tcw_pkg::PRINT_HI);
  assign is_cr       = (code_q == tcw_pkg::CODE_CR);
  assign col_adv     = printable ? ({1'b0, cursor_col_q} + COL_ONE) : {1'b0, cursor_col_q};
  assign wrap        = is_cr || (col_adv == COL_END);
  assign row_adv     = {1'b0, cursor_row_q} + {{RIW{1'b0}}, wrap};
  assign cur_prow    = phys_row(cursor_row_q, top_q);
  assign rd_in_range = (32'(rcol_q) < COLUMNS) && (32'(rrow_q) < ROWS);
  assign rd_prow     = phys_row(RIW'(rrow_q), top_q);
  assign top_next    = (top_q == ROW_LAST) ? '0 : top_q + RIW'(1);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    code_d       = code_q;
    rcol_d       = rcol_q;
    rrow_d       = rrow_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    top_d        = top_q;
    fill_d       = fill_q;
    row_valid_d  = row_valid_q;
    cell_d       = cell_q;
    scrolled_d   = scrolled_q;
    ram_we       = 1'b0;
    ram_addr     = cell_addr(cur_prow, cursor_col_q);
    ram_wdata    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = in_i.data.cmd;
          code_d  = code_in;
          rcol_d  = in_i.data.read_col;
          rrow_d  = in_i.data.read_row;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cell_d     = '0;
        scrolled_d = 1'b0;
        state_d    = ST_RESP;
        unique case (cmd_q)
          tcw_pkg::CMD_WRITE: begin
            if (printable && !row_valid_q[cur_prow]) begin
              fill_d  = '0;
              state_d = ST_FILL;
            end else begin
              ram_we       = printable;
              ram_wdata    = code_q;
              cursor_col_d = wrap ? '0 : col_adv[CIW-1:0];
              if (row_adv == ROW_END) begin
                cursor_row_d        = ROW_LAST;
                row_valid_d[top_q]  = 1'b0;
                top_d               = top_next;
                scrolled_d          = 1'b1;
              end else begin
                cursor_row_d = row_adv[RIW-1:0];
              end
            end
          end
          tcw_pkg::CMD_READ: begin
            if (rd_in_range && row_valid_q[rd_prow]) begin
              ram_addr = cell_addr(rd_prow, CIW'(rcol_q));
              state_d  = ST_RDATA;
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            cursor_col_d = '0;
            cursor_row_d = '0;
            top_d        = '0;
            for (int i = 0; i < ROWS; i++) begin
              row_valid_d[i] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      ST_FILL: begin
        ram_we   = 1'b1;
        ram_addr = cell_addr(cur_prow, fill_q);
        if (fill_q == COL_LAST) begin
          row_valid_d[cur_prow] = 1'b1;
          state_d               = ST_EXEC;
        end else begin
          fill_d = fill_q + CIW'(1);
        end
      end
      ST_RDATA: begin
        cell_d  = ram_rdata;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= '0;
      code_q       <= '0;
      rcol_q       <= '0;
      rrow_q       <= '0;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      top_q        <= '0;
      fill_q       <= '0;
      cell_q       <= '0;
      scrolled_q   <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        row_valid_q[i] <= 1'b0;
      end
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      code_q       <= code_d;
      rcol_q       <= rcol_d;
      rrow_q       <= rrow_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      top_q        <= top_d;
      fill_q       <= fill_d;
      cell_q       <= cell_d;
      scrolled_q   <= scrolled_d;
      row_valid_q  <= row_valid_d;
    end
  end

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = (state_q == ST_RESP);
  assign out_o.data.cell_char  = cell_q;
  assign out_o.data.cursor_col = tcw_pkg::COL_W'(cursor_col_q);
  assign out_o.data.cursor_row = tcw_pkg::ROW_W'(cursor_row_q);
  assign out_o.data.scrolled   = scrolled_q;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a result is pending");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_EXEC || state_q == ST_FILL))
    else $error("cell RAM written outside execute or fill");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cursor_col_q) < COLUMNS) && (32'(cursor_row_q) < ROWS) && (32'(top_q) < ROWS))
    else $error("cursor or top row outside the screen");

  a_scroll_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && scrolled_q) |-> (cursor_row_q == ROW_LAST && cursor_col_q == '0))
    else $error("scroll reported with cursor off the bottom row start");

  a_fill_marks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && fill_q == COL_LAST) |=> row_valid_q[$past(cur_prow)])
    else $error("row sweep finished without marking the row");
`endif

endmodule

// ----- src/tcw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 960
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
